// File: rtl/tpr_pkg.sv
// Package for the tachometer period-to-speed block.
// Holds the item structs, register indexes, state codes and fixed widths.
// No dependencies.
`default_nettype none

package tpr_pkg;

  localparam int unsigned TICKS_W   = 16;
  localparam int unsigned SPEED_W   = 24;
  localparam int unsigned MS_W      = 32;
  localparam int unsigned STALE_W   = 16;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned CFG_DAT_W = 24;
  localparam int unsigned QCNT_W    = 5;

  localparam logic [SPEED_W-1:0] SPEED_CONST_RST = 24'd857143;
  localparam logic [STALE_W-1:0] STALE_LIMIT_RST = 16'd250;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_CONSTANT = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STALE_LIMIT    = 4'd1;

  // Input item function codes
  localparam logic FUNC_EDGE = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  typedef struct packed {
    logic               func;
    logic [TICKS_W-1:0] capture_ticks;
  } tpr_in_t;

  typedef struct packed {
    logic [SPEED_W-1:0] speed_rpm;
    logic               reading_valid;
    logic [MS_W-1:0]    last_edge_ms;
  } tpr_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_RESULT
  } tpr_state_t;

endpackage : tpr_pkg

`default_nettype wire

// File: rtl/tachometer_period_to_rpm_top.sv
// Top level of the tachometer: edge/tick sequencer, state and config registers.
// Depends on tpr_pkg and tpr_div.
//
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall  | tpr_in_t  (func, capture_ticks)
//  out     | output    | out_valid/out_stall| tpr_out_t (speed_rpm, reading_valid,
//          |           |                    |            last_edge_ms)
//  cfg     | input     | cfg_valid/cfg_ready| cfg_index, cfg_wdata
//
// A tick item, or an edge that needs no divide, goes from accept to the result step,
// which loads the result register; the next item is accepted back in idle. An edge
// that divides passes the divide step first (24 divider steps, then the sequencer
// takes the quotient) and the result step loads the result; the next item waits for idle.
// in_stall stays high from accept until the result is loaded; a stalled output
// holds the sequencer in its result step. Reset (rst_n, synchronous) restores
// the register defaults and clears all tracking state. cfg_ready is always high.
`default_nettype none

module tachometer_period_to_rpm_top #(
  parameter int unsigned TIMESTAMP_BITS = 16
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_valid,
  output logic                            in_stall,
  input  wire tpr_pkg::tpr_in_t           in_data,
  output logic                            out_valid,
  input  wire                             out_stall,
  output tpr_pkg::tpr_out_t               out_data,
  input  wire                             cfg_valid,
  output logic                            cfg_ready,
  input  wire [tpr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire [tpr_pkg::CFG_DAT_W-1:0]    cfg_wdata
);
  import tpr_pkg::*;

  localparam int unsigned TS_W = TIMESTAMP_BITS;

  tpr_state_t state_r, state_nxt;

  logic [SPEED_W-1:0] speed_const_r;
  logic [STALE_W-1:0] stale_limit_r;
  logic [TS_W-1:0]    prev_ts_r, prev_ts_nxt;
  logic [SPEED_W-1:0] held_speed_r, held_speed_nxt;
  logic               seen_r, seen_nxt;
  logic [MS_W-1:0]    ms_r, ms_nxt;
  logic [MS_W-1:0]    edge_ms_r, edge_ms_nxt;
  logic               out_valid_r, out_valid_nxt;
  tpr_out_t           out_data_r, out_data_nxt;

  logic               accept;
  logic               need_div;
  logic               div_start;
  logic               div_done;
  logic [SPEED_W-1:0] div_quot;
  logic               out_free;
  logic               result_load;
  logic [TS_W-1:0]    stamp;
  logic [TS_W-1:0]    delta;
  logic [47:0]        ticks_ext;
  logic [MS_W-1:0]    age;

  assign cfg_ready = 1'b1;

  // timestamp at the configured width, zero-extended past the captured bits
  assign ticks_ext = {32'b0, in_data.capture_ticks};
  assign stamp     = ticks_ext[TS_W-1:0];
  assign delta     = TS_W'(stamp - prev_ts_r);
  assign need_div  = (in_data.func == FUNC_EDGE) && seen_r && (delta != '0);
  assign out_free  = !out_valid_r || !out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = need_div ? ST_DIV : ST_RESULT;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall    = 1'b1;
    div_start   = 1'b0;
    result_load = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall  = 1'b0;
        div_start = in_valid && need_div;
      end
      ST_DIV: begin
        in_stall = 1'b1;
      end
      ST_RESULT: begin
        result_load = out_free;
      end
      default: in_stall = 1'b1;
    endcase
  end

  assign accept = in_valid && !in_stall;

  tpr_div #(
    .DEN_W(TS_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (speed_const_r),
    .den   (delta),
    .done  (div_done),
    .quot  (div_quot)
  );

  // tracking state
  always_comb begin
    prev_ts_nxt    = prev_ts_r;
    held_speed_nxt = held_speed_r;
    seen_nxt       = seen_r;
    ms_nxt         = ms_r;
    edge_ms_nxt    = edge_ms_r;
    if (accept) begin
      if (in_data.func == FUNC_TICK) begin
        ms_nxt = ms_r + MS_W'(1);
      end else begin
        prev_ts_nxt = stamp;
        edge_ms_nxt = ms_r;
        seen_nxt    = 1'b1;
      end
    end
    if (state_r == ST_DIV && div_done) begin
      held_speed_nxt = div_quot;
    end
  end

  // result register
  assign age = ms_r - edge_ms_r;

  always_comb begin
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (result_load) begin
      out_valid_nxt              = 1'b1;
      out_data_nxt.speed_rpm     = seen_r ? held_speed_r : '0;
      out_data_nxt.reading_valid = seen_r && (age <= {16'b0, stale_limit_r});
      out_data_nxt.last_edge_ms  = edge_ms_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      speed_const_r <= SPEED_CONST_RST;
      stale_limit_r <= STALE_LIMIT_RST;
      prev_ts_r     <= '0;
      held_speed_r  <= '0;
      seen_r        <= 1'b0;
      ms_r          <= '0;
      edge_ms_r     <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      prev_ts_r    <= prev_ts_nxt;
      held_speed_r <= held_speed_nxt;
      seen_r       <= seen_nxt;
      ms_r         <= ms_nxt;
      edge_ms_r    <= edge_ms_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        // drop writes to unknown indexes
        if (cfg_index == REG_SPEED_CONSTANT) begin
          speed_const_r <= cfg_wdata[SPEED_W-1:0];
        end else if (cfg_index == REG_STALE_LIMIT) begin
          stale_limit_r <= cfg_wdata[STALE_W-1:0];
        end
      end
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule : tachometer_period_to_rpm_top

`default_nettype wire

// File: rtl/tpr_div.sv
// Iterative restoring divider: 24-bit dividend by a DEN_W-bit divisor.
// One quotient bit per cycle; uses tpr_pkg for widths.
`default_nettype none

module tpr_div #(
  parameter int unsigned DEN_W = 16
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        start,
  input  wire [tpr_pkg::SPEED_W-1:0] num,
  input  wire [DEN_W-1:0]            den,
  output logic                       done,
  output logic [tpr_pkg::SPEED_W-1:0] quot
);
  import tpr_pkg::*;

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic [SPEED_W-1:0]  num_r, num_nxt;
  logic [DEN_W-1:0]    rem_r, rem_nxt;
  logic [DEN_W-1:0]    den_r, den_nxt;
  logic [DEN_W:0]      rem_sh;
  logic                ge;
  logic                last_step;

  always_comb begin
    rem_sh    = {rem_r, num_r[SPEED_W-1]};
    ge        = (rem_sh >= {1'b0, den_r});
    last_step = (cnt_r == QCNT_W'(SPEED_W - 1));

    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;

    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      num_nxt  = num;
      rem_nxt  = '0;
      den_nxt  = den;
    end else if (busy_r) begin
      // shift in one dividend bit, subtract when it fits
      rem_nxt = ge ? DEN_W'(rem_sh - {1'b0, den_r}) : rem_sh[DEN_W-1:0];
      num_nxt = {num_r[SPEED_W-2:0], ge};
      cnt_nxt = cnt_r + QCNT_W'(1);
      if (last_step) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quot = num_r;

endmodule : tpr_div

`default_nettype wire
